// File: hw/rtl/polar_line_rasterizer_macros.svh
// Assertion helpers shared by the rasterizer modules.
// Each macro expects clock in the caller; PRL_ASSERT also needs reset.
`ifndef POLAR_LINE_RASTERIZER_MACROS_SVH
`define POLAR_LINE_RASTERIZER_MACROS_SVH

// Checked on every clock edge outside of reset.
`define PRL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define PRL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// File: hw/rtl/prl_pkg.sv
package prl_pkg;

   // Screen bounds and the longest line that is drawn.
   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 1024;
   localparam int MAX_LENGTH    = 64;

   // Angles in whole degrees.
   localparam int QUARTER_TURN  = 90;
   localparam int HALF_TURN     = 180;
   localparam int THREE_QUARTER = 270;
   localparam int FULL_TURN     = 360;

   // Field widths.
   localparam int COORD_W = 12;
   localparam int ERR_W   = 10;
   localparam int TRIG_W  = 17;

   // Folded angle: index into the quarter-wave table and the sign of the result.
   typedef struct packed {
      logic [6:0] idx;
      logic       neg;
   } prl_fold_type;

   // Setup handed from the sequencer to the line walker.
   typedef struct packed {
      logic                       start;
      logic                       shallow;
      logic signed [COORD_W-1:0]  maj_start;
      logic signed [COORD_W-1:0]  maj_end;
      logic signed [COORD_W-1:0]  min_start;
      logic                       step_neg;
      logic signed [ERR_W-1:0]    err_init;
      logic [7:0]                 two_min;
      logic [7:0]                 two_maj;
   } prl_walk_cmd_type;

   // Maps any angle from 0 to 511 degrees onto the first quadrant.
   function automatic prl_fold_type trig_fold(input logic [8:0] angle);
      logic [8:0]   a;
      prl_fold_type f;
      a = (angle >= 9'(FULL_TURN)) ? angle - 9'(FULL_TURN) : angle;
      priority if (a <= 9'(QUARTER_TURN)) begin
         f.idx = a[6:0];
         f.neg = 1'b0;
      end else if (a <= 9'(HALF_TURN)) begin
         f.idx = 7'(9'(HALF_TURN) - a);
         f.neg = 1'b0;
      end else if (a <= 9'(THREE_QUARTER)) begin
         f.idx = 7'(a - 9'(HALF_TURN));
         f.neg = 1'b1;
      end else begin
         f.idx = 7'(9'(FULL_TURN) - a);
         f.neg = 1'b1;
      end
      return f;
   endfunction

   // Sine of 0 to 90 degrees in Q16, rounded half up.
   function automatic logic [TRIG_W-1:0] sine_q16(input logic [6:0] idx);
      logic [TRIG_W-1:0] s;
      unique case (idx)
         7'd0:  s = 17'd0;     7'd1:  s = 17'd1144;  7'd2:  s = 17'd2287;
         7'd3:  s = 17'd3430;  7'd4:  s = 17'd4572;  7'd5:  s = 17'd5712;
         7'd6:  s = 17'd6850;  7'd7:  s = 17'd7987;  7'd8:  s = 17'd9121;
         7'd9:  s = 17'd10252; 7'd10: s = 17'd11380; 7'd11: s = 17'd12505;
         7'd12: s = 17'd13626; 7'd13: s = 17'd14742; 7'd14: s = 17'd15855;
         7'd15: s = 17'd16962; 7'd16: s = 17'd18064; 7'd17: s = 17'd19161;
         7'd18: s = 17'd20252; 7'd19: s = 17'd21336; 7'd20: s = 17'd22415;
         7'd21: s = 17'd23486; 7'd22: s = 17'd24550; 7'd23: s = 17'd25607;
         7'd24: s = 17'd26656; 7'd25: s = 17'd27697; 7'd26: s = 17'd28729;
         7'd27: s = 17'd29753; 7'd28: s = 17'd30767; 7'd29: s = 17'd31772;
         7'd30: s = 17'd32768; 7'd31: s = 17'd33754; 7'd32: s = 17'd34729;
         7'd33: s = 17'd35693; 7'd34: s = 17'd36647; 7'd35: s = 17'd37590;
         7'd36: s = 17'd38521; 7'd37: s = 17'd39441; 7'd38: s = 17'd40348;
         7'd39: s = 17'd41243; 7'd40: s = 17'd42126; 7'd41: s = 17'd42995;
         7'd42: s = 17'd43852; 7'd43: s = 17'd44695; 7'd44: s = 17'd45525;
         7'd45: s = 17'd46341; 7'd46: s = 17'd47143; 7'd47: s = 17'd47930;
         7'd48: s = 17'd48703; 7'd49: s = 17'd49461; 7'd50: s = 17'd50203;
         7'd51: s = 17'd50931; 7'd52: s = 17'd51643; 7'd53: s = 17'd52339;
         7'd54: s = 17'd53020; 7'd55: s = 17'd53684; 7'd56: s = 17'd54332;
         7'd57: s = 17'd54963; 7'd58: s = 17'd55578; 7'd59: s = 17'd56175;
         7'd60: s = 17'd56756; 7'd61: s = 17'd57319; 7'd62: s = 17'd57865;
         7'd63: s = 17'd58393; 7'd64: s = 17'd58903; 7'd65: s = 17'd59396;
         7'd66: s = 17'd59870; 7'd67: s = 17'd60326; 7'd68: s = 17'd60764;
         7'd69: s = 17'd61183; 7'd70: s = 17'd61584; 7'd71: s = 17'd61966;
         7'd72: s = 17'd62328; 7'd73: s = 17'd62672; 7'd74: s = 17'd62997;
         7'd75: s = 17'd63303; 7'd76: s = 17'd63589; 7'd77: s = 17'd63856;
         7'd78: s = 17'd64104; 7'd79: s = 17'd64332; 7'd80: s = 17'd64540;
         7'd81: s = 17'd64729; 7'd82: s = 17'd64898; 7'd83: s = 17'd65048;
         7'd84: s = 17'd65177; 7'd85: s = 17'd65287; 7'd86: s = 17'd65376;
         7'd87: s = 17'd65446; 7'd88: s = 17'd65496; 7'd89: s = 17'd65526;
         7'd90: s = 17'd65536;
         default: s = 17'd0;
      endcase
      return s;
   endfunction

endpackage

// File: hw/rtl/prl_end_unit.sv
// Shared end point unit: one axis per cycle, two pipeline stages.
// Stage one looks up the trig value and multiplies it by the length,
// stage two adds the start point in Q16 and truncates toward zero.
module prl_end_unit (
   input  logic                                 clock,
   input  logic [9:0]                           op_start,
   input  logic [8:0]                           op_angle,
   input  logic [6:0]                           op_len,
   output logic signed [prl_pkg::COORD_W-1:0]   end_coord
);

   prl_pkg::prl_fold_type        fold;
   logic [prl_pkg::TRIG_W-1:0]   trig_mag;
   logic [23:0]                  prod_mag;
   logic signed [23:0]           product_in;
   logic signed [23:0]           product_ff;
   logic [9:0]                   start_ff;
   logic signed [27:0]           sum;
   logic                         round_up;
   logic signed [prl_pkg::COORD_W-1:0] end_in;
   logic signed [prl_pkg::COORD_W-1:0] end_ff;

   // Stage one: table lookup and the single multiplier.
   always_comb begin
      fold       = prl_pkg::trig_fold(op_angle);
      trig_mag   = prl_pkg::sine_q16(fold.idx);
      prod_mag   = {7'b0, trig_mag} * {17'b0, op_len};
      product_in = fold.neg ? -signed'(prod_mag) : signed'(prod_mag);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      start_ff   <= op_start;
   end

   // Stage two: add the start point and truncate toward zero.
   always_comb begin
      sum      = signed'({2'b00, start_ff, 16'h0000}) + 28'(product_ff);
      round_up = sum[27] && (sum[15:0] != 16'h0000);
      end_in   = sum[27:16] + {11'b0, round_up};
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
   end

   assign end_coord = end_ff;

endmodule

// File: hw/rtl/prl_line_walk.sv
`include "polar_line_rasterizer_macros.svh"

// Bresenham stepper: one pixel per cycle along the major axis, written into
// an output register that holds while the receiver stalls.
module prl_line_walk (
   input  logic                                 clock,
   input  logic                                 reset,
   input  prl_pkg::prl_walk_cmd_type            walk_cmd,
   input  logic [31:0]                          color,
   output logic                                 walk_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [prl_pkg::COORD_W-1:0]   rsp_pix_x,
   output logic signed [prl_pkg::COORD_W-1:0]   rsp_pix_y,
   output logic [31:0]                          rsp_pix_color,
   output logic                                 rsp_in_screen,
   output logic                                 rsp_last_pixel
);

   logic                                 busy_ff, busy_in;
   logic                                 shallow_ff;
   logic signed [prl_pkg::COORD_W-1:0]   maj_ff, maj_in;
   logic signed [prl_pkg::COORD_W-1:0]   maj_end_ff;
   logic signed [prl_pkg::COORD_W-1:0]   min_ff, min_in;
   logic                                 step_neg_ff;
   logic signed [prl_pkg::ERR_W-1:0]     err_ff, err_in;
   logic [7:0]                           two_min_ff;
   logic [7:0]                           two_maj_ff;
   logic                                 valid_ff, valid_in;
   logic signed [prl_pkg::COORD_W-1:0]   pix_x_ff, pix_x_in;
   logic signed [prl_pkg::COORD_W-1:0]   pix_y_ff, pix_y_in;
   logic [31:0]                          color_ff;
   logic                                 in_screen_ff, in_screen_in;
   logic                                 last_ff, last_in;
   logic                                 load;
   logic                                 step_minor;
   logic signed [prl_pkg::COORD_W-1:0]   maj_next;

   // A pixel moves into the output register when it is empty or draining.
   assign load     = busy_ff && (!valid_ff || rsp_ready);
   assign maj_next = maj_ff + 12'sd1;

   // Pixel position, bounds flag and the next Bresenham step.
   always_comb begin
      pix_x_in     = shallow_ff ? maj_ff : min_ff;
      pix_y_in     = shallow_ff ? min_ff : maj_ff;
      in_screen_in = !pix_x_in[prl_pkg::COORD_W-1] && !pix_y_in[prl_pkg::COORD_W-1]
                     && (13'($unsigned(pix_x_in)) < 13'(prl_pkg::SCREEN_WIDTH))
                     && (13'($unsigned(pix_y_in)) < 13'(prl_pkg::SCREEN_HEIGHT));
      last_in      = (maj_next == maj_end_ff);
      if (shallow_ff) begin
         step_minor = !err_ff[prl_pkg::ERR_W-1];
      end else begin
         step_minor = !err_ff[prl_pkg::ERR_W-1] && (err_ff != '0);
      end
      maj_in = maj_next;
      min_in = min_ff;
      err_in = err_ff + signed'({2'b00, two_min_ff});
      if (step_minor) begin
         min_in = step_neg_ff ? min_ff - 12'sd1 : min_ff + 12'sd1;
         err_in = err_ff + signed'({2'b00, two_min_ff}) - signed'({2'b00, two_maj_ff});
      end
   end

   // Busy from a start command until the last pixel is loaded.
   always_comb begin
      busy_in = busy_ff;
      if (walk_cmd.start) begin
         busy_in = 1'b1;
      end else if (load && last_in) begin
         busy_in = 1'b0;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   // Walk state: loaded on start, advanced with each transfer into the output.
   always_ff @(posedge clock) begin
      if (walk_cmd.start) begin
         shallow_ff  <= walk_cmd.shallow;
         maj_ff      <= walk_cmd.maj_start;
         maj_end_ff  <= walk_cmd.maj_end;
         min_ff      <= walk_cmd.min_start;
         step_neg_ff <= walk_cmd.step_neg;
         err_ff      <= walk_cmd.err_init;
         two_min_ff  <= walk_cmd.two_min;
         two_maj_ff  <= walk_cmd.two_maj;
      end else if (load) begin
         maj_ff <= maj_in;
         min_ff <= min_in;
         err_ff <= err_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (load) begin
         pix_x_ff     <= pix_x_in;
         pix_y_ff     <= pix_y_in;
         color_ff     <= color;
         in_screen_ff <= in_screen_in;
         last_ff      <= last_in;
      end
   end

   assign walk_busy      = busy_ff;
   assign rsp_valid      = valid_ff;
   assign rsp_pix_x      = pix_x_ff;
   assign rsp_pix_y      = pix_y_ff;
   assign rsp_pix_color  = color_ff;
   assign rsp_in_screen  = in_screen_ff;
   assign rsp_last_pixel = last_ff;

   `PRL_ASSERT(a_start_when_free, walk_cmd.start |-> !busy_ff, "walk started while busy")
   `PRL_ASSERT(a_last_ends_walk, (load && last_in) |=> !busy_ff, "walk ran past the last pixel")
   `PRL_ASSERT(a_valid_follows_load, load |=> (valid_ff && (rsp_last_pixel == $past(last_in))), "loaded pixel not presented")
   `PRL_ASSERT_ALWAYS(a_reset_clears, reset |=> (!valid_ff && !busy_ff), "reset left a pixel pending")

endmodule

// File: hw/rtl/polar_line_rasterizer.sv
// Polar line rasterizer.
// The req_ channel takes one line: start point, length in pixels, direction in
// whole degrees and a color. The rsp_ channel returns the pixels of the line in
// walk order, each with its color, an in-screen flag and a mark on the last one.
// Lengths above 64 are treated as 64, angles from 360 up wrap once.
// A line whose walk would be empty returns no pixels at all.
// Both channels transfer on a clock edge where valid and ready are high.
// req_ready is high only while the block is idle; one line is handled at a time.
// After a transfer on req_ the sequencer runs MUL_X, MUL_Y, FIN and SETUP
// before the walk starts; the end points come from one shared table and
// multiplier unit used for the x axis and then the y axis.
// The walker then loads one pixel per cycle into the output register while
// rsp_ is not stalled.
// A stall on rsp_ holds the pixel in the output register and pauses the walk;
// the next line may be accepted while the last pixel still waits to be taken.
// Synchronous reset clears the sequencer and the output valid; no pixel is lost
// or repeated across a stall.
`include "polar_line_rasterizer_macros.svh"

module polar_line_rasterizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [9:0]                           req_start_x,
   input  logic [9:0]                           req_start_y,
   input  logic [6:0]                           req_line_length,
   input  logic [8:0]                           req_angle_deg,
   input  logic [31:0]                          req_pixel_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [prl_pkg::COORD_W-1:0]   rsp_pix_x,
   output logic signed [prl_pkg::COORD_W-1:0]   rsp_pix_y,
   output logic [31:0]                          rsp_pix_color,
   output logic                                 rsp_in_screen,
   output logic                                 rsp_last_pixel
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL_X = 3'd1;
   localparam logic [2:0] S_MUL_Y = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_SETUP = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;

   logic [2:0]                           state_ff, state_in;
   logic [9:0]                           start_x_ff;
   logic [9:0]                           start_y_ff;
   logic [6:0]                           len_ff;
   logic [8:0]                           ang_ff;
   logic [31:0]                          color_ff;
   logic signed [prl_pkg::COORD_W-1:0]   x1_ff;
   logic                                 req_xfer;
   logic [6:0]                           len_sat;
   logic [8:0]                           ang_red;
   logic [9:0]                           op_start;
   logic [8:0]                           op_angle;
   logic signed [prl_pkg::COORD_W-1:0]   end_coord;
   logic signed [prl_pkg::COORD_W-1:0]   x0, y0, y1, dxr, dyr;
   logic [6:0]                           adx, ady;
   logic                                 empty_walk;
   logic                                 walk_busy;
   prl_pkg::prl_walk_cmd_type            walk_cmd;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Clamp the length and wrap the angle once on the way in.
   always_comb begin
      len_sat = (req_line_length > 7'(prl_pkg::MAX_LENGTH))
                ? 7'(prl_pkg::MAX_LENGTH) : req_line_length;
      ang_red = (req_angle_deg >= 9'(prl_pkg::FULL_TURN))
                ? req_angle_deg - 9'(prl_pkg::FULL_TURN) : req_angle_deg;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         start_x_ff <= req_start_x;
         start_y_ff <= req_start_y;
         len_ff     <= len_sat;
         ang_ff     <= ang_red;
         color_ff   <= req_pixel_color;
      end
      if (state_ff == S_FIN) begin
         x1_ff <= end_coord;
      end
   end

   // The shared unit sees the cosine operands first, then the sine operands.
   always_comb begin
      if (state_ff == S_MUL_X) begin
         op_start = start_x_ff;
         op_angle = ang_ff + 9'(prl_pkg::QUARTER_TURN);
      end else begin
         op_start = start_y_ff;
         op_angle = ang_ff;
      end
   end

   prl_end_unit u_end (
      .clock     (clock),
      .op_start  (op_start),
      .op_angle  (op_angle),
      .op_len    (len_ff),
      .end_coord (end_coord)
   );

   // Walk setup: pick the major axis, order the ends and seed the error term.
   always_comb begin
      x0  = signed'({2'b00, start_x_ff});
      y0  = signed'({2'b00, start_y_ff});
      y1  = end_coord;
      dxr = x1_ff - x0;
      dyr = y1 - y0;
      adx = 7'(dxr[prl_pkg::COORD_W-1] ? -dxr : dxr);
      ady = 7'(dyr[prl_pkg::COORD_W-1] ? -dyr : dyr);
      walk_cmd.shallow = (ady < adx);
      if (walk_cmd.shallow) begin
         walk_cmd.maj_start = dxr[prl_pkg::COORD_W-1] ? x1_ff : x0;
         walk_cmd.maj_end   = dxr[prl_pkg::COORD_W-1] ? x0 : x1_ff;
         walk_cmd.min_start = dxr[prl_pkg::COORD_W-1] ? y1 : y0;
         walk_cmd.step_neg  = dxr[prl_pkg::COORD_W-1]
                              ? (!dyr[prl_pkg::COORD_W-1] && (dyr != '0))
                              : dyr[prl_pkg::COORD_W-1];
         walk_cmd.two_min   = {ady, 1'b0};
         walk_cmd.two_maj   = {adx, 1'b0};
      end else begin
         walk_cmd.maj_start = dyr[prl_pkg::COORD_W-1] ? y1 : y0;
         walk_cmd.maj_end   = dyr[prl_pkg::COORD_W-1] ? y0 : y1;
         walk_cmd.min_start = dyr[prl_pkg::COORD_W-1] ? x1_ff : x0;
         walk_cmd.step_neg  = dyr[prl_pkg::COORD_W-1]
                              ? (!dxr[prl_pkg::COORD_W-1] && (dxr != '0))
                              : dxr[prl_pkg::COORD_W-1];
         walk_cmd.two_min   = {adx, 1'b0};
         walk_cmd.two_maj   = {ady, 1'b0};
      end
      walk_cmd.err_init = signed'({2'b00, walk_cmd.two_min})
                          - signed'({3'b000, walk_cmd.two_maj[7:1]});
      empty_walk     = (walk_cmd.maj_start == walk_cmd.maj_end);
      walk_cmd.start = (state_ff == S_SETUP) && !empty_walk;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_xfer) state_in = S_MUL_X;
         S_MUL_X: state_in = S_MUL_Y;
         S_MUL_Y: state_in = S_FIN;
         S_FIN:   state_in = S_SETUP;
         S_SETUP: state_in = empty_walk ? S_IDLE : S_WALK;
         S_WALK:  if (!walk_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   prl_line_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .walk_cmd       (walk_cmd),
      .color          (color_ff),
      .walk_busy      (walk_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pix_x      (rsp_pix_x),
      .rsp_pix_y      (rsp_pix_y),
      .rsp_pix_color  (rsp_pix_color),
      .rsp_in_screen  (rsp_in_screen),
      .rsp_last_pixel (rsp_last_pixel)
   );

   `PRL_ASSERT(a_walk_only_in_walk, walk_busy |-> (state_ff == S_WALK), "walker busy outside walk")
   `PRL_ASSERT(a_accept_starts_math, req_xfer |=> (state_ff == S_MUL_X && !walk_busy), "transfer did not start setup")

endmodule
